// File: src/tatb_pkg.sv
// Package for the turntable axis to scratch button block.
// Holds the word types, the spin direction codes and the register indexes.
// Depends on nothing.
package tatb_pkg;

    typedef enum logic [1:0]
    {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef enum logic [0:0]
    {
        CFG_DEBOUNCE     = 1'b0,
        CFG_STOP_TIMEOUT = 1'b1
    } cfg_idx_t;

    localparam logic ACTION_AXIS = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd0;
    localparam logic [CFG_W-1:0] STOP_TIMEOUT_RESET = 16'd100;

    typedef struct packed
    {
        logic               action;
        logic [1:0]         play_mode;
        logic               turntable;
        logic signed [15:0] axis_value;
        logic [31:0]        stamp_ms;
    } in_word_t;

    typedef struct packed
    {
        logic        lane;
        logic        pressed;
        logic [31:0] event_ms;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed
    {
        logic [1:0] cnt;
        out_word_t  first;
        out_word_t  second;
    } out_pair_t;

    typedef struct packed
    {
        logic [15:0] axis_prev;
        dir_t        spin_dir;
        logic [31:0] moved_ms;
        logic [31:0] pressed_ms;
    } slot_t;

endpackage

// File: src/tatb_core.sv
// Per-mode, per-turntable state, configuration registers and the event decision.
// Reads the slots of the registered input word and updates them when it is processed.
// Depends on tatb_pkg.
module tatb_core #(
    parameter int MODES      = 4,
    parameter int TURNTABLES = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tatb_pkg::in_word_t  item,
    input  logic                proc,
    input  logic                cfg_wen,
    input  tatb_pkg::cfg_idx_t  cfg_idx,
    input  logic [15:0]         cfg_wdata,
    output tatb_pkg::out_pair_t pair
);
    import tatb_pkg::*;

    localparam int MODE_IX_W = (MODES > 1) ? $clog2(MODES) : 1;
    localparam int TT_IX_W   = 1;

    function automatic logic turns_cw(input logic [15:0] prev, input logic [15:0] curr);
        logic signed [17:0] d;
        d = $signed({{2{curr[15]}}, curr}) - $signed({{2{prev[15]}}, prev});
        if (d < -18'sd16384)
        begin
            d = d + 18'sd32768;
        end
        if (d > 18'sd16384)
        begin
            d = d - 18'sd32768;
        end
        return d > 18'sd0;
    endfunction

    slot_t slot_reg [TURNTABLES][MODES];
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] timeout_reg;

    logic [MODE_IX_W-1:0] mode_ix;
    logic [TT_IX_W-1:0]   tt_ix;
    logic                 mode_ok;
    logic                 tt_ok;

    slot_t                cur       [TURNTABLES];
    slot_t                slot_next [TURNTABLES];
    dir_t                 dir       [TURNTABLES];
    logic [TURNTABLES-1:0] changed;
    logic [TURNTABLES-1:0] press_ok;
    logic [TURNTABLES-1:0] stale;
    logic [TURNTABLES-1:0] wr_en;
    logic [1:0]            rel2;

    assign mode_ix = MODE_IX_W'(item.play_mode);
    assign tt_ix   = TT_IX_W'(item.turntable);
    assign mode_ok = int'(item.play_mode) < MODES;
    assign tt_ok   = int'(item.turntable) < TURNTABLES;

    for (genvar t = 0; t < TURNTABLES; t++)
    begin : g_tt
        logic [31:0] since_move;
        logic [31:0] since_press;

        assign cur[t]      = slot_reg[t][mode_ix];
        assign since_move  = item.stamp_ms - cur[t].moved_ms;
        assign since_press = item.stamp_ms - cur[t].pressed_ms;
        assign dir[t]      = turns_cw(cur[t].axis_prev, item.axis_value) ? DIR_CW : DIR_CCW;
        assign changed[t]  = cur[t].axis_prev != item.axis_value;
        assign press_ok[t] = (dir[t] != cur[t].spin_dir)
                             && (since_press > {16'd0, debounce_reg});
        assign stale[t]    = (cur[t].spin_dir != DIR_NONE)
                             && (since_move > {16'd0, timeout_reg});
    end

    assign rel2 = 2'(stale);

    always_comb
    begin
        pair  = '0;
        wr_en = '0;
        for (int t = 0; t < TURNTABLES; t++)
        begin
            slot_next[t] = cur[t];
        end
        if (mode_ok)
        begin
            if (item.action == ACTION_TICK)
            begin
                for (int t = 0; t < TURNTABLES; t++)
                begin
                    if (stale[t])
                    begin
                        wr_en[t]              = 1'b1;
                        slot_next[t].spin_dir = DIR_NONE;
                    end
                end
            end
            else if (tt_ok && changed[tt_ix])
            begin
                wr_en[tt_ix]               = 1'b1;
                slot_next[tt_ix].axis_prev = item.axis_value;
                slot_next[tt_ix].moved_ms  = item.stamp_ms;
                if (press_ok[tt_ix])
                begin
                    slot_next[tt_ix].spin_dir   = dir[tt_ix];
                    slot_next[tt_ix].pressed_ms = item.stamp_ms;
                    if (cur[tt_ix].spin_dir != DIR_NONE)
                    begin
                        pair.cnt            = 2'd2;
                        pair.first.lane     = item.turntable;
                        pair.first.pressed  = 1'b0;
                        pair.second.lane    = item.turntable;
                        pair.second.pressed = 1'b1;
                    end
                    else
                    begin
                        pair.cnt           = 2'd1;
                        pair.first.lane    = item.turntable;
                        pair.first.pressed = 1'b1;
                    end
                end
            end
        end
        if (mode_ok && item.action == ACTION_TICK)
        begin
            case (rel2)
                2'b01:
                begin
                    pair.cnt        = 2'd1;
                    pair.first.lane = 1'b0;
                end
                2'b10:
                begin
                    pair.cnt        = 2'd1;
                    pair.first.lane = 1'b1;
                end
                2'b11:
                begin
                    pair.cnt         = 2'd2;
                    pair.first.lane  = 1'b0;
                    pair.second.lane = 1'b1;
                end
                default:
                begin
                    pair.cnt = 2'd0;
                end
            endcase
        end
        pair.first.event_ms     = item.stamp_ms;
        pair.second.event_ms    = item.stamp_ms;
        pair.first.last_of_run  = pair.cnt == 2'd1;
        pair.second.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TURNTABLES; t++)
            begin
                for (int m = 0; m < MODES; m++)
                begin
                    slot_reg[t][m] <= '0;
                end
            end
        end
        else if (proc)
        begin
            for (int t = 0; t < TURNTABLES; t++)
            begin
                for (int m = 0; m < MODES; m++)
                begin
                    if (wr_en[t] && mode_ix == MODE_IX_W'(m))
                    begin
                        slot_reg[t][m] <= slot_next[t];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            timeout_reg  <= STOP_TIMEOUT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_DEBOUNCE:     debounce_reg <= cfg_wdata;
                CFG_STOP_TIMEOUT: timeout_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

endmodule

// File: src/tatb_out.sv
// Result register for the turntable block: holds up to two words of one input word.
// Presents them in order on the output channel.
// Depends on tatb_pkg.
module tatb_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tatb_pkg::out_pair_t pair,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output tatb_pkg::out_word_t out_data
);
    import tatb_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    out_word_t  first_reg;
    out_word_t  first_next;
    out_word_t  second_reg;
    out_word_t  second_next;
    logic       taken;

    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = first_reg;
    assign taken     = out_valid && out_ready;
    assign room      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (load)
        begin
            cnt_next    = pair.cnt;
            first_next  = pair.first;
            second_next = pair.second;
        end
        else if (taken)
        begin
            if (cnt_reg == 2'd2)
            begin
                cnt_next   = 2'd1;
                first_next = second_reg;
            end
            else
            begin
                cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

endmodule

// File: src/turntable_axis_to_button.sv
// Top level of the turntable axis to scratch button block.
// Instantiates tatb_core and tatb_out around an input register; depends on tatb_pkg.
//
// Each accepted word is held in an input register and decided in one pass against the
// stored turntable state; its zero, one or two result words are loaded into the result
// register as soon as that register has room. The input register can take the next word
// while the current one is processed. A word that gives two results occupies the result
// register until both have been taken, and a stall on the output holds the flow.
// Configuration writes take effect at the clock edge of the write.
module turntable_axis_to_button #(
    parameter int MODES      = 4,
    parameter int TURNTABLES = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tatb_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tatb_pkg::out_word_t out_data,
    input  logic                cfg_wen,
    input  tatb_pkg::cfg_idx_t  cfg_idx,
    input  logic [15:0]         cfg_wdata
);
    import tatb_pkg::*;

    in_word_t  in_data_reg;
    logic      in_full_reg;
    logic      in_full_next;
    logic      room;
    logic      proc;
    out_pair_t pair;

    assign proc     = in_full_reg && room;
    assign in_ready = !in_full_reg || proc;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (proc)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    tatb_core #(
        .MODES      (MODES),
        .TURNTABLES (TURNTABLES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_data_reg),
        .proc      (proc),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .pair      (pair)
    );

    tatb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc),
        .pair      (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: src/tatb_checker.sv
// Checker on the output channel of the turntable block, bound to the top level.
// Depends on tatb_pkg.
module tatb_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input tatb_pkg::out_word_t out_data
);
    import tatb_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before the word was taken");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output word changed while stalled");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("second word of a pair not presented at once");

    a_first_is_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |-> !out_data.pressed)
        else $error("first word of a pair is not a release");

    a_pair_same_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run
        |=> out_data.event_ms == $past(out_data.event_ms))
        else $error("words of one pair carry different times");

endmodule

bind turntable_axis_to_button tatb_checker u_checker (.*);
